// ===== sv/rna_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational ALU package
// Command, status and compare codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package rna_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd3;

    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_MLOAD   = 12'b000000000010,
        S_MUL     = 12'b000000000100,
        S_ADDSUB  = 12'b000000001000,
        S_NEGDIFF = 12'b000000010000,
        S_CMP     = 12'b000000100000,
        S_RED     = 12'b000001000000,
        S_GCDX    = 12'b000010000000,
        S_GCDL    = 12'b000100000000,
        S_DIVN    = 12'b001000000000,
        S_DIVD    = 12'b010000000000,
        S_FIN     = 12'b100000000000
    } state_t;

endpackage

// ===== sv/rational_number_alu_core.sv =====
// ----------------------------------------------------------------------------
// Rational number ALU core
// Path from input transfer to out_valid: an item flagged at the input goes
// straight to the finish state; compare runs the shift-add multiply for three
// products, then the compare; arithmetic runs the multiplies, a binary GCD on
// 2W-bit values and exact division of numerator and denominator.
// Throughput: one item in flight, bounded by the single shared 2W+2 bit adder;
// next transfer in the cycle after the result loads, a held result stalls input.
// Reset: rst_n asynchronous, active low; sequencer to idle, out_valid low.
// ----------------------------------------------------------------------------
module rational_number_alu_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         order,
    output logic [1:0]         status
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * W;          // product width
    localparam int AW = PW + 2;         // shared adder width, sign in msb
    localparam int CW = $clog2(PW + 1); // step counter
    localparam int KW = $clog2(PW + 1); // common power-of-two count

    rna_pkg::state_t state_reg;

    // operand signs and magnitudes
    logic [2:0]   cmd_reg;
    logic         sa_n_reg, sa_d_reg, sb_n_reg, sb_d_reg;
    logic [W-1:0] ma_n_reg, ma_d_reg, mb_n_reg, mb_d_reg;

    // multiplier
    logic [1:0]    sel_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] mc_reg, acc_reg;
    logic [W-1:0]  mq_reg;

    // products: p holds the numerator, d the denominator after combining
    logic [PW-1:0] p_reg, q_reg, d_reg;
    logic          neg_reg, zero_reg;
    logic [1:0]    status_reg, order_reg;

    // gcd and division
    logic [PW-1:0] gx_reg, gy_reg, g_reg, rem_reg, dv_reg;
    logic [KW-1:0] k_reg;

    // output stage
    logic          out_valid_reg;
    logic [31:0]   res_num_reg;
    logic [30:0]   res_den_reg;
    logic [1:0]    order_out_reg, status_out_reg;

    // ------------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------------
    logic [W-1:0] an_w, ad_w, bn_w, bd_w;
    assign an_w = a_num[W-1:0];
    assign ad_w = a_den[W-1:0];
    assign bn_w = b_num[W-1:0];
    assign bd_w = b_den[W-1:0];

    logic in_xfer;
    assign in_ready = (state_reg == rna_pkg::S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    logic is_cmp;
    assign is_cmp = (cmd_reg >= rna_pkg::CMD_CMP);   // unused codes act as compare

    // ------------------------------------------------------------------------
    // Multiplier operand select: P, Q, D in turn
    // ------------------------------------------------------------------------
    logic [W-1:0] op_a, op_b;
    always_comb
    begin
        case (sel_reg)
            2'd0:
            begin
                op_a = ma_n_reg;
                op_b = (cmd_reg == rna_pkg::CMD_MUL) ? mb_n_reg : mb_d_reg;
            end
            2'd1:
            begin
                op_a = mb_n_reg;
                op_b = ma_d_reg;
            end
            default:
            begin
                op_a = ma_d_reg;
                op_b = (cmd_reg == rna_pkg::CMD_DIV) ? mb_n_reg : mb_d_reg;
            end
        endcase
    end

    // signs of the cross terms (zero magnitude counts as positive)
    logic pneg, qneg, dneg_as;
    assign pneg    = (sa_n_reg ^ sb_d_reg) && (p_reg != '0);
    assign qneg    = (sb_n_reg ^ sa_d_reg ^ (cmd_reg == rna_pkg::CMD_SUB)) && (q_reg != '0);
    assign dneg_as = sa_d_reg ^ sb_d_reg;

    logic pneg_c, qneg_c;
    assign pneg_c = (sa_n_reg ^ sa_d_reg) && (p_reg != '0);
    assign qneg_c = (sb_n_reg ^ sb_d_reg) && (q_reg != '0);

    // ------------------------------------------------------------------------
    // Shared adder / subtractor
    // ------------------------------------------------------------------------
    logic [AW-1:0] add_x, add_y, add_res;
    logic          add_sub;
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            rna_pkg::S_MUL:
            begin
                add_x = AW'(acc_reg);
                add_y = mq_reg[0] ? AW'(mc_reg) : '0;
            end
            rna_pkg::S_ADDSUB:
            begin
                add_x   = AW'(p_reg);
                add_y   = AW'(q_reg);
                add_sub = (pneg != qneg);
            end
            rna_pkg::S_NEGDIFF:
            begin
                add_x   = AW'(q_reg);
                add_y   = AW'(p_reg);
                add_sub = 1'b1;
            end
            rna_pkg::S_CMP:
            begin
                add_x   = AW'(p_reg);
                add_y   = AW'(q_reg);
                add_sub = 1'b1;
            end
            rna_pkg::S_GCDL:
            begin
                add_x   = AW'(gx_reg);
                add_y   = AW'(gy_reg);
                add_sub = 1'b1;
            end
            rna_pkg::S_DIVN, rna_pkg::S_DIVD:
            begin
                add_x   = AW'({rem_reg, dv_reg[PW-1]});
                add_y   = AW'(g_reg);
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_res = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
    end

    logic add_neg;
    assign add_neg = add_res[AW-1];

    // ------------------------------------------------------------------------
    // Result formatting
    // ------------------------------------------------------------------------
    logic [PW-1:0] lim;
    logic          ovf;
    logic [W-1:0]  num_w;
    assign lim   = PW'(1) << (W - 1);
    assign ovf   = (d_reg > lim - PW'(1)) || (p_reg > (neg_reg ? lim : lim - PW'(1)));
    assign num_w = neg_reg ? (~p_reg[W-1:0] + W'(1)) : p_reg[W-1:0];

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rna_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads in the same cycle as the old one leaves
            if (state_reg == rna_pkg::S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                rna_pkg::S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= (ad_w == '0 || bd_w == '0 ||
                                      (cmd == rna_pkg::CMD_DIV && bn_w == '0))
                                     ? rna_pkg::S_FIN : rna_pkg::S_MLOAD;
                    end
                end
                rna_pkg::S_MLOAD:
                begin
                    state_reg <= rna_pkg::S_MUL;
                end
                rna_pkg::S_MUL:
                begin
                    if (cnt_reg == CW'(W - 1))
                    begin
                        if (sel_reg != 2'd2)
                        begin
                            state_reg <= rna_pkg::S_MLOAD;
                        end
                        else if (is_cmp)
                        begin
                            state_reg <= rna_pkg::S_CMP;
                        end
                        else if (cmd_reg == rna_pkg::CMD_ADD || cmd_reg == rna_pkg::CMD_SUB)
                        begin
                            state_reg <= rna_pkg::S_ADDSUB;
                        end
                        else
                        begin
                            state_reg <= rna_pkg::S_RED;
                        end
                    end
                end
                rna_pkg::S_ADDSUB:
                begin
                    state_reg <= (pneg != qneg && add_neg) ? rna_pkg::S_NEGDIFF
                                                          : rna_pkg::S_RED;
                end
                rna_pkg::S_NEGDIFF:
                begin
                    state_reg <= rna_pkg::S_RED;
                end
                rna_pkg::S_CMP:
                begin
                    state_reg <= rna_pkg::S_FIN;
                end
                rna_pkg::S_RED:
                begin
                    state_reg <= (p_reg == '0) ? rna_pkg::S_FIN : rna_pkg::S_GCDX;
                end
                rna_pkg::S_GCDX:
                begin
                    if (gx_reg[0] || gy_reg[0])
                    begin
                        state_reg <= rna_pkg::S_GCDL;
                    end
                end
                rna_pkg::S_GCDL:
                begin
                    if (gx_reg == '0)
                    begin
                        state_reg <= rna_pkg::S_DIVN;
                    end
                end
                rna_pkg::S_DIVN:
                begin
                    if (cnt_reg == CW'(PW - 1))
                    begin
                        state_reg <= rna_pkg::S_DIVD;
                    end
                end
                rna_pkg::S_DIVD:
                begin
                    if (cnt_reg == CW'(PW - 1))
                    begin
                        state_reg <= rna_pkg::S_FIN;
                    end
                end
                rna_pkg::S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= rna_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= rna_pkg::S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rna_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_reg    <= cmd;
                    sa_n_reg   <= an_w[W-1];
                    sa_d_reg   <= ad_w[W-1];
                    sb_n_reg   <= bn_w[W-1];
                    sb_d_reg   <= bd_w[W-1];
                    ma_n_reg   <= an_w[W-1] ? (~an_w + W'(1)) : an_w;
                    ma_d_reg   <= ad_w[W-1] ? (~ad_w + W'(1)) : ad_w;
                    mb_n_reg   <= bn_w[W-1] ? (~bn_w + W'(1)) : bn_w;
                    mb_d_reg   <= bd_w[W-1] ? (~bd_w + W'(1)) : bd_w;
                    sel_reg    <= 2'd0;
                    zero_reg   <= 1'b0;
                    order_reg  <= rna_pkg::ORDER_EQUAL;
                    if (ad_w == '0 || bd_w == '0)
                    begin
                        status_reg <= rna_pkg::STATUS_ZERO_DEN;
                    end
                    else if (cmd == rna_pkg::CMD_DIV && bn_w == '0)
                    begin
                        status_reg <= rna_pkg::STATUS_DIV_ZERO;
                    end
                    else
                    begin
                        status_reg <= rna_pkg::STATUS_OK;
                    end
                end
            end
            rna_pkg::S_MLOAD:
            begin
                mc_reg  <= PW'(op_a);
                mq_reg  <= op_b;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            rna_pkg::S_MUL:
            begin
                acc_reg <= add_res[PW-1:0];
                mc_reg  <= mc_reg << 1;
                mq_reg  <= mq_reg >> 1;
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    case (sel_reg)
                        2'd0:    p_reg <= add_res[PW-1:0];
                        2'd1:    q_reg <= add_res[PW-1:0];
                        default: d_reg <= add_res[PW-1:0];
                    endcase
                    sel_reg <= sel_reg + 2'd1;
                    // mul: n = an*bn, d = ad*bd; div: n = an*bd, d = ad*bn
                    if (cmd_reg == rna_pkg::CMD_MUL)
                    begin
                        neg_reg <= sa_n_reg ^ sb_n_reg ^ sa_d_reg ^ sb_d_reg;
                    end
                    else
                    begin
                        neg_reg <= sa_n_reg ^ sb_d_reg ^ sa_d_reg ^ sb_n_reg;
                    end
                end
            end
            rna_pkg::S_ADDSUB:
            begin
                if (pneg == qneg || !add_neg)
                begin
                    p_reg   <= add_res[PW-1:0];
                    neg_reg <= pneg ^ dneg_as;
                end
                else
                begin
                    neg_reg <= qneg ^ dneg_as;
                end
            end
            rna_pkg::S_NEGDIFF:
            begin
                p_reg <= add_res[PW-1:0];
            end
            rna_pkg::S_CMP:
            begin
                if (pneg_c != qneg_c)
                begin
                    order_reg <= pneg_c ? rna_pkg::ORDER_LESS : rna_pkg::ORDER_GREATER;
                end
                else if (p_reg == q_reg)
                begin
                    order_reg <= rna_pkg::ORDER_EQUAL;
                end
                else if (add_neg ^ pneg_c)
                begin
                    order_reg <= rna_pkg::ORDER_LESS;
                end
                else
                begin
                    order_reg <= rna_pkg::ORDER_GREATER;
                end
            end
            rna_pkg::S_RED:
            begin
                zero_reg <= (p_reg == '0);
                gx_reg   <= p_reg;
                gy_reg   <= d_reg;
                k_reg    <= '0;
            end
            rna_pkg::S_GCDX:
            begin
                if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    k_reg  <= k_reg + KW'(1);
                end
            end
            rna_pkg::S_GCDL:
            begin
                if (gx_reg == '0)
                begin
                    g_reg   <= gy_reg << k_reg;
                    rem_reg <= '0;
                    dv_reg  <= p_reg;
                    cnt_reg <= '0;
                end
                else if (!gx_reg[0])
                begin
                    gx_reg <= gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_reg <= gy_reg >> 1;
                end
                else if (add_neg)
                begin
                    gx_reg <= gy_reg;
                    gy_reg <= gx_reg;
                end
                else
                begin
                    gx_reg <= add_res[PW-1:0];
                end
            end
            rna_pkg::S_DIVN, rna_pkg::S_DIVD:
            begin
                // restoring division, one quotient bit a step
                if (cnt_reg == CW'(PW - 1))
                begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    if (state_reg == rna_pkg::S_DIVN)
                    begin
                        p_reg  <= {dv_reg[PW-2:0], !add_neg};
                        dv_reg <= d_reg;
                    end
                    else
                    begin
                        d_reg <= {dv_reg[PW-2:0], !add_neg};
                    end
                end
                else
                begin
                    rem_reg <= add_neg ? {rem_reg[PW-2:0], dv_reg[PW-1]} : add_res[PW-1:0];
                    dv_reg  <= {dv_reg[PW-2:0], !add_neg};
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            rna_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    order_out_reg <= order_reg;
                    if (status_reg != rna_pkg::STATUS_OK)
                    begin
                        status_out_reg <= status_reg;
                        res_num_reg    <= '0;
                        res_den_reg    <= '0;
                    end
                    else if (is_cmp)
                    begin
                        status_out_reg <= rna_pkg::STATUS_OK;
                        res_num_reg    <= '0;
                        res_den_reg    <= '0;
                    end
                    else if (zero_reg)
                    begin
                        status_out_reg <= rna_pkg::STATUS_OK;
                        res_num_reg    <= '0;
                        res_den_reg    <= 31'd1;
                    end
                    else if (ovf)
                    begin
                        status_out_reg <= rna_pkg::STATUS_OVERFLOW;
                        res_num_reg    <= '0;
                        res_den_reg    <= '0;
                    end
                    else
                    begin
                        status_out_reg <= rna_pkg::STATUS_OK;
                        res_num_reg    <= 32'($signed(num_w));
                        res_den_reg    <= 31'(d_reg[W-2:0]);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign order     = order_out_reg;
    assign status    = status_out_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != rna_pkg::STATUS_OK
        |-> res_num == '0 && res_den == '0 && order == rna_pkg::ORDER_EQUAL)
        else $error("error result carries a value");

    a_cmp_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && order != rna_pkg::ORDER_EQUAL |-> res_den == '0)
        else $error("compare result carries a denominator");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new transfer taken while busy");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Rational ALU core testbench
// Directed table of corner cases, then random fractions, with random idling
// on both channels and one long output hold-off. Each result is checked
// against its row value or an in-bench model of fraction arithmetic and GCD.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         ord;
        logic [1:0]         st;
    } frac_res_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } smag_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
        bit                 typed;   // expected value given in the row
        frac_res_t          res;
    } vec_t;

    localparam int N_RANDOM   = 1500;
    localparam int HOLD_CYC   = 900;  // long receiver hold-off
    localparam int HOLD_AT    = 300;

    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         cmd;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         order;
    logic [1:0]         status;

    frac_res_t pending_res[$];
    int        n_errors   = 0;
    int        n_received = 0;
    int        n_sent     = 0;
    int        n_errs_seen = 0;   // results carrying an error status

    rational_number_alu_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .order     (order),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---- fraction arithmetic model ----------------------------------------
    function automatic logic [63:0] mag64(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic smag_t sm_mul(longint x, longint y);
        smag_t r;
        r.mag = mag64(x) * mag64(y);
        r.neg = ((x < 0) != (y < 0)) && (r.mag != 0);
        return r;
    endfunction

    function automatic smag_t sm_add(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end
        else if (x.mag >= y.mag)
        begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end
        else
        begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic frac_res_t reduce_fraction_op(logic [2:0] op,
        logic signed [31:0] an32, logic signed [31:0] ad32,
        logic signed [31:0] bn32, logic signed [31:0] bd32);
        frac_res_t   r;
        longint      an, ad, bn, bd, na, da, nb, db, lhs, rhs;
        smag_t       n, d, p, q;
        logic [63:0] g, nm, dm;
        logic        neg;
        an = an32; ad = ad32; bn = bn32; bd = bd32;
        r = '{num: '0, den: '0, ord: rna_pkg::ORDER_EQUAL, st: rna_pkg::STATUS_OK};
        if (ad == 0 || bd == 0)
            r.st = rna_pkg::STATUS_ZERO_DEN;
        else if (op >= rna_pkg::CMD_CMP)
        begin
            na = (ad < 0) ? -an : an;  da = (ad < 0) ? -ad : ad;
            nb = (bd < 0) ? -bn : bn;  db = (bd < 0) ? -bd : bd;
            lhs = na * db;
            rhs = nb * da;
            r.ord = (lhs < rhs) ? rna_pkg::ORDER_LESS
                  : (lhs == rhs) ? rna_pkg::ORDER_EQUAL : rna_pkg::ORDER_GREATER;
        end
        else if (op == rna_pkg::CMD_DIV && bn == 0)
            r.st = rna_pkg::STATUS_DIV_ZERO;
        else
        begin
            if (op == rna_pkg::CMD_MUL)
            begin
                n = sm_mul(an, bn);
                d = sm_mul(ad, bd);
            end
            else if (op == rna_pkg::CMD_DIV)
            begin
                n = sm_mul(an, bd);
                d = sm_mul(ad, bn);
            end
            else
            begin
                p = sm_mul(an, bd);
                q = sm_mul(bn, ad);
                if (op == rna_pkg::CMD_SUB && q.mag != 0)
                    q.neg = ~q.neg;
                n = sm_add(p, q);
                d = sm_mul(ad, bd);
            end
            if (n.mag == 0)
                r.den = 31'd1;
            else
            begin
                g   = gcd64(n.mag, d.mag);
                neg = n.neg ^ d.neg;
                nm  = n.mag / g;
                dm  = d.mag / g;
                if (dm > 64'h7fff_ffff || nm > (neg ? 64'h8000_0000 : 64'h7fff_ffff))
                    r.st = rna_pkg::STATUS_OVERFLOW;
                else
                begin
                    r.num = neg ? 32'(-nm) : 32'(nm);
                    r.den = 31'(dm);
                end
            end
        end
        return r;
    endfunction

    // ---- result checker ----------------------------------------------------
    always @(posedge clk)
    begin
        frac_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_received <= n_received + 1;
            if (status != rna_pkg::STATUS_OK)
                n_errs_seen <= n_errs_seen + 1;
            if (pending_res.size() == 0)
            begin
                $error("result transfer with nothing expected");
                n_errors++;
            end
            else
            begin
                want = pending_res.pop_front();
                if (res_num !== want.num)
                begin
                    $error("res_num: expected %0d, got %0d", want.num, res_num);
                    n_errors++;
                end
                if (res_den !== want.den)
                begin
                    $error("res_den: expected %0d, got %0d", want.den, res_den);
                    n_errors++;
                end
                if (order !== want.ord)
                begin
                    $error("order: expected %0d, got %0d", want.ord, order);
                    n_errors++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    n_errors++;
                end
            end
        end
    end

    // ---- receiver: random stalls, one long hold-off -----------------------
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = (n_received == HOLD_AT) ? HOLD_CYC
                : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // ---- sender --------------------------------------------------------------
    task automatic send_item(vec_t v, int gap);
        frac_res_t exp_res;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd      <= v.op;
        a_num    <= v.an;
        a_den    <= v.ad;
        b_num    <= v.bn;
        b_den    <= v.bd;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        // transfer happened at this edge
        exp_res = v.typed ? v.res
            : reduce_fraction_op(v.op, v.an, v.ad, v.bn, v.bd);
        pending_res.insert(pending_res.size(), exp_res);
        n_sent++;
    endtask

    function automatic logic signed [31:0] pick_value(bit is_den);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return is_den ? 32'sd0 : 32'sd0;
            2:       return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
            3:       return 32'($urandom_range(0, 65535)) - 32'sd32768;
            default: return 32'($urandom_range(0, 40)) - 32'sd20;
        endcase
    endfunction

    vec_t dir_tab[] = '{
        '{rna_pkg::CMD_ADD, 1, 2, 1, 3, 0, '0},
        '{rna_pkg::CMD_ADD, 1, 0, 1, 3, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_ZERO_DEN}},
        '{rna_pkg::CMD_CMP, 1, 2, 1, 0, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_ZERO_DEN}},
        '{rna_pkg::CMD_DIV, 0, 0, 0, 5, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_ZERO_DEN}},
        '{rna_pkg::CMD_DIV, 3, 4, 0, 5, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_DIV_ZERO}},
        '{rna_pkg::CMD_MUL, S_MAX, 1, S_MAX, 1, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OVERFLOW}},
        '{rna_pkg::CMD_MUL, S_MIN, 1, -1, 1, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OVERFLOW}},
        '{rna_pkg::CMD_ADD, 0, 5, 0, 7, 1,
          '{0, 1, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_SUB, 7, 9, 7, 9, 1,
          '{0, 1, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_ADD, S_MIN, 1, 0, 1, 1,
          '{S_MIN, 1, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_DIV, S_MIN, S_MIN, 1, 1, 1,
          '{1, 1, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_CMP, 1, 2, 2, 4, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_CMP, -1, 2, 1, 3, 1,
          '{0, 0, rna_pkg::ORDER_LESS, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_CMP, 3, 1, 1, 1, 1,
          '{0, 0, rna_pkg::ORDER_GREATER, rna_pkg::STATUS_OK}},
        '{3'(rna_pkg::CMD_CMP + 1), 3, 1, 1, 1, 1,
          '{0, 0, rna_pkg::ORDER_GREATER, rna_pkg::STATUS_OK}},
        '{3'(rna_pkg::CMD_CMP + 2), 1, -2, 1, 2, 1,
          '{0, 0, rna_pkg::ORDER_LESS, rna_pkg::STATUS_OK}},
        '{3'(rna_pkg::CMD_CMP + 3), S_MIN, S_MIN, S_MAX, S_MAX, 1,
          '{0, 0, rna_pkg::ORDER_EQUAL, rna_pkg::STATUS_OK}},
        '{rna_pkg::CMD_CMP, S_MIN, 1, S_MAX, S_MIN, 0, '0},
        '{rna_pkg::CMD_SUB, S_MIN, S_MAX, S_MAX, S_MIN, 0, '0},
        '{rna_pkg::CMD_MUL, -6, -4, 2, 3, 0, '0},
        '{rna_pkg::CMD_DIV, S_MAX, S_MIN, S_MIN, S_MAX, 0, '0},
        '{rna_pkg::CMD_ADD, S_MAX, S_MAX, S_MIN, S_MIN, 0, '0},
        '{rna_pkg::CMD_DIV, 5, -3, -10, 9, 0, '0}
    };

    initial
    begin
        vec_t v;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = rna_pkg::CMD_ADD;
        a_num    = '0;
        a_den    = 32'sd1;
        b_num    = '0;
        b_den    = 32'sd1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i], $urandom_range(0, 11));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            v.op    = 3'($urandom_range(0, 7));
            v.an    = pick_value(1'b0);
            v.ad    = pick_value(1'b1);
            v.bn    = pick_value(1'b0);
            v.bd    = pick_value(1'b1);
            v.typed = 1'b0;
            v.res   = '0;
            // steer most items away from the zero-denominator short cut
            if ($urandom_range(0, 7) != 0)
            begin
                if (v.ad == 0) v.ad = 32'sd1;
                if (v.bd == 0) v.bd = -32'sd1;
            end
            send_item(v, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 11));
        end
        in_valid <= 1'b0;

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);

        $display("Run covered %0d transfers in, %0d results out (%0d with error status),",
                 n_sent, n_received, n_errs_seen);
        $display("all five commands, aliased compare codes, extremes and error cases.");
        if (n_errors == 0 && pending_res.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rna_pkg.sv
sv/rational_number_alu_core.sv
tb/sv/tb.sv
